// ===== src/framebuffer_fill_engine_unit_assert.svh =====
// assertion macros used by the checker file of the fill engine
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef FRAMEBUFFER_FILL_ENGINE_UNIT_ASSERT_SVH
`define FRAMEBUFFER_FILL_ENGINE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define FFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ffe_pkg.sv =====
// shared types and constants of the framebuffer fill engine
// no dependencies; used by every module of the block
package ffe_pkg;

	// fixed field widths
	localparam int OpW     = 2;
	localparam int PosW    = 10;
	localparam int RadiusW = 7;
	localparam int ColorW  = 24;
	localparam int DimW    = 7;
	localparam int LimW    = 11;

	// internal widths: coordinates with disc offsets, disc offsets, root, radicand
	localparam int CoordW = 12;
	localparam int OffW   = 8;
	localparam int RootW  = 6;
	localparam int SqW    = 2 * RootW;

	localparam logic [ColorW-1:0] ClearColor = 24'h0000FF;

	typedef enum logic [OpW-1:0] {
		OP_PLOT = 2'd0,
		OP_RECT = 2'd1,
		OP_DISC = 2'd2,
		OP_READ = 2'd3
	} opcode_t;

	// datapath steps issued by the controller
	typedef enum logic [3:0] {
		DP_NONE,
		DP_CLEAR,
		DP_PIXEL,
		DP_READ,
		DP_RECT,
		DP_SQRT,
		DP_ROWS,
		DP_DISC,
		DP_NEXT_COL
	} step_t;

	typedef struct packed {
		logic  load;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic rect_empty;
		logic rect_last;
		logic sqrt_done;
		logic col_empty;
		logic row_last;
		logic col_last;
		logic clear_last;
		logic rd_done;
	} status_t;

	// one pixel access entering the pixel pipeline
	typedef struct packed {
		logic              valid;
		logic              wr;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [ColorW-1:0] color;
	} pix_req_t;

endpackage

// ===== src/ffe_isqrt.sv =====
// iterative integer square root, one result bit per cycle
// depends on ffe_pkg
module ffe_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ffe_pkg::SqW-1:0]  radicand,
	output logic                     done,
	output logic [ffe_pkg::RootW-1:0] root
);

	logic                      busy_q;
	logic                      done_q;
	logic [ffe_pkg::SqW-1:0]   n_q;
	logic [ffe_pkg::RootW-1:0] root_q;
	logic [ffe_pkg::RootW-1:0] mask_q;
	logic [ffe_pkg::RootW-1:0] trial;
	logic [ffe_pkg::SqW-1:0]   trial_sq;

	// candidate root with the current bit set
	assign trial    = root_q | mask_q;
	assign trial_sq = ffe_pkg::SqW'(trial) * ffe_pkg::SqW'(trial);

	// run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mask_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// root bits, msb first
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			root_q <= '0;
			mask_q <= {1'b1, {(ffe_pkg::RootW-1){1'b0}}};
		end else if (busy_q) begin
			if (trial_sq <= n_q) begin
				root_q <= trial;
			end
			mask_q <= mask_q >> 1;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== src/ffe_pixpipe.sv =====
// pixel pipeline: clip, address, frame memory access and the clearing sweep
// depends on ffe_pkg
module ffe_pixpipe #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffe_pkg::pix_req_t         req,
	input  logic                      clear_en,
	input  logic [ffe_pkg::DimW-1:0]  active_w,
	input  logic [ffe_pkg::DimW-1:0]  active_h,
	output logic                      clear_last,
	output logic                      rd_valid,
	output logic [ffe_pkg::ColorW-1:0] rd_data
);

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AddrW = $clog2(Depth);
	localparam int LinW  = 2 * ffe_pkg::DimW + 1;

	logic                        vld_s1;
	logic                        wr_s1;
	logic [ffe_pkg::CoordW-1:0]  x_s1;
	logic [ffe_pkg::CoordW-1:0]  y_s1;
	logic [ffe_pkg::ColorW-1:0]  color_s1;
	logic                        vld_s2;
	logic                        wr_s2;
	logic                        in_s2;
	logic [AddrW-1:0]            addr_s2;
	logic [ffe_pkg::ColorW-1:0]  color_s2;
	logic                        rvld_s3;
	logic                        rin_s3;
	logic [ffe_pkg::ColorW-1:0]  rdata_s3;
	logic [AddrW-1:0]            clr_q;
	logic [ffe_pkg::ColorW-1:0]  pix_mem_q [Depth];
	logic                        in_frame;
	logic [LinW-1:0]             lin;
	logic                        mem_we;
	logic [AddrW-1:0]            mem_waddr;
	logic [ffe_pkg::ColorW-1:0]  mem_wdata;

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			rvld_s3 <= 1'b0;
		end else begin
			vld_s1  <= req.valid;
			vld_s2  <= vld_s1;
			rvld_s3 <= vld_s2 && !wr_s2;
		end
	end

	// stage 1: request register
	always_ff @(posedge clk) begin
		wr_s1    <= req.wr;
		x_s1     <= req.x;
		y_s1     <= req.y;
		color_s1 <= req.color;
	end

	// clip test; negative coordinates wrap high and fail the compare
	assign in_frame = (x_s1 < ffe_pkg::CoordW'(active_w)) &&
		(y_s1 < ffe_pkg::CoordW'(active_h));

	// row-major address, stride is the active width
	assign lin = LinW'(y_s1[ffe_pkg::DimW-1:0]) * LinW'(active_w) +
		LinW'(x_s1[ffe_pkg::DimW-1:0]);

	// stage 2: clip result and address
	always_ff @(posedge clk) begin
		wr_s2    <= wr_s1;
		in_s2    <= in_frame;
		addr_s2  <= AddrW'(lin);
		color_s2 <= color_s1;
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clear_en) begin
			clr_q <= clr_q + AddrW'(1);
		end
	end

	assign clear_last = (clr_q == AddrW'(Depth - 1));

	// single write port shared by the sweep and pixel writes
	assign mem_we    = clear_en || (vld_s2 && wr_s2 && in_s2);
	assign mem_waddr = clear_en ? clr_q : addr_s2;
	assign mem_wdata = clear_en ? ffe_pkg::ClearColor : color_s2;

	// frame memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pix_mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_s3 <= pix_mem_q[addr_s2];
	end

	always_ff @(posedge clk) begin
		rin_s3 <= in_s2;
	end

	// pixels outside the frame read as zero
	assign rd_valid = rvld_s3;
	assign rd_data  = rin_s3 ? rdata_s3 : '0;

endmodule

// ===== src/ffe_dpath.sv =====
// datapath: command fields, rectangle and disc walk counters, read result
// depends on ffe_pkg, ffe_isqrt, ffe_pixpipe
module ffe_dpath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffe_pkg::cmd_t                     cmd,
	input  logic signed [ffe_pkg::PosW-1:0]   start_x,
	input  logic signed [ffe_pkg::PosW-1:0]   start_y,
	input  logic signed [ffe_pkg::PosW-1:0]   end_x,
	input  logic signed [ffe_pkg::PosW-1:0]   end_y,
	input  logic signed [ffe_pkg::RadiusW-1:0] radius,
	input  logic [ffe_pkg::ColorW-1:0]        color,
	input  logic [ffe_pkg::DimW-1:0]          active_w,
	input  logic [ffe_pkg::DimW-1:0]          active_h,
	output ffe_pkg::status_t                  status,
	output logic [ffe_pkg::ColorW-1:0]        read_color
);

	localparam int CW = ffe_pkg::CoordW;
	localparam int OW = ffe_pkg::OffW;
	localparam int RW = ffe_pkg::RootW;
	localparam int SW = ffe_pkg::SqW;

	logic [ffe_pkg::ColorW-1:0] color_q;
	logic [ffe_pkg::ColorW-1:0] read_color_q;
	logic signed [CW-1:0]       sx_q;
	logic signed [CW-1:0]       sy_q;
	logic signed [CW-1:0]       x1_q;
	logic signed [CW-1:0]       x2_q;
	logic signed [CW-1:0]       y2_q;
	logic signed [CW-1:0]       cx_q;
	logic signed [CW-1:0]       cy_q;
	logic [RW-1:0]              rad_q;
	logic signed [OW-1:0]       dx_q;
	logic signed [OW-1:0]       dy_q;

	logic signed [CW-1:0] sx_ext;
	logic signed [CW-1:0] sy_ext;
	logic signed [CW-1:0] ex_ext;
	logic signed [CW-1:0] ey_ext;
	logic signed [CW-1:0] w_last;
	logic signed [CW-1:0] h_last;
	logic signed [CW-1:0] x1;
	logic signed [CW-1:0] y1;
	logic signed [CW-1:0] x2;
	logic signed [CW-1:0] y2;
	logic [OW-1:0]        dx_abs;
	logic [SW-1:0]        radicand;
	logic                 sqrt_done;
	logic [RW-1:0]        root;
	logic                 clear_last;
	logic                 rd_valid;
	logic [ffe_pkg::ColorW-1:0] rd_data;
	ffe_pkg::pix_req_t    req;

	// clipped rectangle corners; an empty frame gives a last index of -1
	assign sx_ext = CW'(start_x);
	assign sy_ext = CW'(start_y);
	assign ex_ext = CW'(end_x);
	assign ey_ext = CW'(end_y);
	assign w_last = $signed(CW'(active_w) - CW'(1));
	assign h_last = $signed(CW'(active_h) - CW'(1));
	assign x1     = sx_ext[CW-1] ? '0 : sx_ext;
	assign y1     = sy_ext[CW-1] ? '0 : sy_ext;
	assign x2     = (ex_ext > w_last) ? w_last : ex_ext;
	assign y2     = (ey_ext > h_last) ? h_last : ey_ext;

	// radicand r*r - dx*dx for the current column
	assign dx_abs   = dx_q[OW-1] ? (OW'(0) - dx_q) : dx_q;
	assign radicand = SW'(rad_q) * SW'(rad_q) - SW'(dx_abs[RW-1:0]) * SW'(dx_abs[RW-1:0]);

	// command fields and walk counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			color_q <= color;
			sx_q    <= sx_ext;
			sy_q    <= sy_ext;
			x1_q    <= x1;
			x2_q    <= x2;
			y2_q    <= y2;
			cx_q    <= x1;
			cy_q    <= y1;
			rad_q   <= radius[RW-1:0];
			dx_q    <= OW'(0) - OW'(radius[RW-1:0]);
		end else begin
			case (cmd.step)
				ffe_pkg::DP_RECT: begin
					if (cx_q == x2_q) begin
						cx_q <= x1_q;
						cy_q <= cy_q + CW'(1);
					end else begin
						cx_q <= cx_q + CW'(1);
					end
				end
				ffe_pkg::DP_ROWS: begin
					dy_q <= OW'(0) - OW'(root);
				end
				ffe_pkg::DP_DISC: begin
					dy_q <= dy_q + OW'(1);
				end
				ffe_pkg::DP_NEXT_COL: begin
					dx_q <= dx_q + OW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// pixel request for the current step
	always_comb begin
		req       = '0;
		req.color = color_q;
		case (cmd.step)
			ffe_pkg::DP_PIXEL: begin
				req.valid = 1'b1;
				req.wr    = 1'b1;
				req.x     = sx_q;
				req.y     = sy_q;
			end
			ffe_pkg::DP_READ: begin
				req.valid = 1'b1;
				req.x     = sx_q;
				req.y     = sy_q;
			end
			ffe_pkg::DP_RECT: begin
				req.valid = 1'b1;
				req.wr    = 1'b1;
				req.x     = cx_q;
				req.y     = cy_q;
			end
			ffe_pkg::DP_DISC: begin
				req.valid = 1'b1;
				req.wr    = 1'b1;
				req.x     = sx_q + CW'(dx_q);
				req.y     = sy_q + CW'(dy_q);
			end
			default: begin
			end
		endcase
	end

	ffe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.step == ffe_pkg::DP_SQRT),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (root)
	);

	ffe_pixpipe #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pixpipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.clear_en   (cmd.step == ffe_pkg::DP_CLEAR),
		.active_w   (active_w),
		.active_h   (active_h),
		.clear_last (clear_last),
		.rd_valid   (rd_valid),
		.rd_data    (rd_data)
	);

	// read result word
	always_ff @(posedge clk) begin
		if (rd_valid) begin
			read_color_q <= rd_data;
		end
	end

	assign read_color = read_color_q;

	// status to the controller
	always_comb begin
		status            = '0;
		status.rect_empty = (cx_q > x2_q) || (cy_q > y2_q);
		status.rect_last  = (cx_q == x2_q) && (cy_q == y2_q);
		status.sqrt_done  = sqrt_done;
		status.col_empty  = (root == '0);
		status.row_last   = (dy_q == $signed(OW'(root) - OW'(1)));
		status.col_last   = (dx_q == $signed(OW'(rad_q) - OW'(1)));
		status.clear_last = clear_last;
		status.rd_done    = rd_valid;
	end

endmodule

// ===== src/ffe_ctrl.sv =====
// controller: command sequencing, clearing sweep and result word handshake
// depends on ffe_pkg
module ffe_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  logic [ffe_pkg::OpW-1:0]           opcode,
	input  logic signed [ffe_pkg::RadiusW-1:0] radius,
	input  logic                              rsp_stall,
	input  ffe_pkg::status_t                  status,
	output logic                              cmd_stall,
	output logic                              rsp_valid,
	output ffe_pkg::cmd_t                     cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PIXEL,
		S_RECT,
		S_READ,
		S_RWAIT,
		S_COL,
		S_SQRT,
		S_ROWS,
		S_NEXT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   rad_pos;

	// a read waits until the result word register is free
	assign cmd_stall = (state_q != S_IDLE) ||
		((opcode == ffe_pkg::OP_READ) && rsp_valid_q);
	assign accept    = cmd_valid && !cmd_stall;
	assign rad_pos   = !radius[ffe_pkg::RadiusW-1] && (radius != '0);

	// next state and datapath step
	always_comb begin
		state_d  = state_q;
		cmd.load = accept;
		cmd.step = ffe_pkg::DP_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd.step = ffe_pkg::DP_CLEAR;
				if (status.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (ffe_pkg::opcode_t'(opcode))
						ffe_pkg::OP_PLOT: state_d = S_PIXEL;
						ffe_pkg::OP_RECT: state_d = S_RECT;
						ffe_pkg::OP_DISC: state_d = rad_pos ? S_COL : S_PIXEL;
						default:          state_d = S_READ;
					endcase
				end
			end
			S_PIXEL: begin
				cmd.step = ffe_pkg::DP_PIXEL;
				state_d  = S_IDLE;
			end
			S_RECT: begin
				if (status.rect_empty) begin
					state_d = S_IDLE;
				end else begin
					cmd.step = ffe_pkg::DP_RECT;
					if (status.rect_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_READ: begin
				cmd.step = ffe_pkg::DP_READ;
				state_d  = S_RWAIT;
			end
			S_RWAIT: begin
				if (status.rd_done) begin
					state_d = S_IDLE;
				end
			end
			S_COL: begin
				cmd.step = ffe_pkg::DP_SQRT;
				state_d  = S_SQRT;
			end
			S_SQRT: begin
				if (status.sqrt_done) begin
					if (status.col_empty) begin
						state_d = status.col_last ? S_IDLE : S_NEXT;
					end else begin
						cmd.step = ffe_pkg::DP_ROWS;
						state_d  = S_ROWS;
					end
				end
			end
			S_ROWS: begin
				cmd.step = ffe_pkg::DP_DISC;
				if (status.row_last) begin
					state_d = status.col_last ? S_IDLE : S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.step = ffe_pkg::DP_NEXT_COL;
				state_d  = S_COL;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_RWAIT) && status.rd_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== src/framebuffer_fill_engine_unit.sv =====
// Framebuffer fill engine, top level: frame registers, controller and datapath.
// Commands arrive on the cmd channel (cmd_valid / cmd_stall) with one port per
// field; read results leave on the rsp channel (rsp_valid / rsp_stall, read_color).
// Frame width and height are written over the APB port at byte addresses 0 and 4.
// After reset a clearing sweep paints the whole store blue, one pixel per cycle;
// cmd_stall stays high until it is done. Register writes are taken at any time.
// Work per command, from acceptance to the next acceptance:
//   plot or disc with radius of zero or less: one pixel write
//   rectangle: one write per pixel of the clipped box, none when the box is empty
//   disc: per column a root start, six root steps, done and a column step, plus
//   one write per row pixel
//   read: a read through the pixel pipeline, then the result word is registered
// The rate is set by the single frame memory port, one pixel access per cycle,
// and by the six-step square root run once per disc column.
// A result word waits in its output register while rsp_stall is high; other
// commands are still taken meanwhile, a further read waits until it is taken.
// depends on ffe_pkg, ffe_ctrl, ffe_dpath
module framebuffer_fill_engine_unit #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [ffe_pkg::OpW-1:0]           opcode,
	input  logic signed [ffe_pkg::PosW-1:0]   start_x,
	input  logic signed [ffe_pkg::PosW-1:0]   start_y,
	input  logic signed [ffe_pkg::PosW-1:0]   end_x,
	input  logic signed [ffe_pkg::PosW-1:0]   end_y,
	input  logic signed [ffe_pkg::RadiusW-1:0] radius,
	input  logic [ffe_pkg::ColorW-1:0]        color,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [ffe_pkg::ColorW-1:0]        read_color,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam logic RegWidthSel  = 1'b0;
	localparam logic RegHeightSel = 1'b1;
	localparam logic [ffe_pkg::LimW-1:0] MaxWidthC  = ffe_pkg::LimW'(MAX_WIDTH);
	localparam logic [ffe_pkg::LimW-1:0] MaxHeightC = ffe_pkg::LimW'(MAX_HEIGHT);

	logic [ffe_pkg::DimW-1:0] frame_width_q;
	logic [ffe_pkg::DimW-1:0] frame_height_q;
	logic [ffe_pkg::DimW-1:0] active_w;
	logic [ffe_pkg::DimW-1:0] active_h;
	logic [ffe_pkg::DimW-1:0] rd_reg;
	logic                     reg_wr;
	ffe_pkg::cmd_t            cmd;
	ffe_pkg::status_t         status;

	// register port, selected by the word address bit
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ffe_pkg::DimW'(64);
			frame_height_q <= ffe_pkg::DimW'(64);
		end else if (reg_wr) begin
			case (paddr[2])
				RegWidthSel:  frame_width_q  <= pwdata[ffe_pkg::DimW-1:0];
				RegHeightSel: frame_height_q <= pwdata[ffe_pkg::DimW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign rd_reg = (paddr[2] == RegHeightSel) ? frame_height_q : frame_width_q;
	assign prdata = 32'(rd_reg);

	// oversized frame registers act as the store size
	assign active_w = (ffe_pkg::LimW'(frame_width_q) > MaxWidthC) ?
		MaxWidthC[ffe_pkg::DimW-1:0] : frame_width_q;
	assign active_h = (ffe_pkg::LimW'(frame_height_q) > MaxHeightC) ?
		MaxHeightC[ffe_pkg::DimW-1:0] : frame_height_q;

	ffe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.opcode    (opcode),
		.radius    (radius),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.cmd       (cmd)
	);

	ffe_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.radius     (radius),
		.color      (color),
		.active_w   (active_w),
		.active_h   (active_h),
		.status     (status),
		.read_color (read_color)
	);

endmodule

// ===== src/ffe_chk.sv =====
// port-level checker for the fill engine, bound to the top level
// depends on ffe_pkg and framebuffer_fill_engine_unit_assert.svh
`include "framebuffer_fill_engine_unit_assert.svh"

module ffe_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_stall,
	input logic [ffe_pkg::OpW-1:0]      opcode,
	input logic                         rsp_valid,
	input logic                         rsp_stall,
	input logic [ffe_pkg::ColorW-1:0]   read_color
);

	// a stalled result word holds
	`FFE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")
	`FFE_ASSERT_NEXT(a_rsp_data_hold, rsp_valid && rsp_stall, $stable(read_color), "result data changed while stalled")

	// a read is only taken while no result word waits
	`FFE_ASSERT_NOW(a_read_slot, cmd_valid && !cmd_stall && opcode == ffe_pkg::OP_READ, !rsp_valid, "read accepted over a pending result")

	// one word per read: no new word right after one is taken
	`FFE_ASSERT_NEXT(a_one_word, rsp_valid && !rsp_stall, !rsp_valid, "extra result word")

	// every command keeps the engine busy in the cycle after it is taken
	`FFE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "command taken back to back")

endmodule

bind framebuffer_fill_engine_unit ffe_chk u_ffe_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd_valid),
	.cmd_stall  (cmd_stall),
	.opcode     (opcode),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.read_color (read_color)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the framebuffer fill engine: plots, fills, reads and frame resizes
// depends on ffe_pkg and framebuffer_fill_engine_unit; keeps its own copy of the pixel store

module testbench;

	localparam int FRAME_MAX = 64;
	localparam int CYCLE_LIMIT = 20_000_000;
	localparam logic [2:0] FRAME_WIDTH_ADDR  = 3'd0;
	localparam logic [2:0] FRAME_HEIGHT_ADDR = 3'd4;

	// one command word as offered on the cmd channel
	typedef struct packed {
		ffe_pkg::opcode_t                op;
		logic [ffe_pkg::PosW-1:0]        sx;
		logic [ffe_pkg::PosW-1:0]        sy;
		logic [ffe_pkg::PosW-1:0]        ex;
		logic [ffe_pkg::PosW-1:0]        ey;
		logic [ffe_pkg::RadiusW-1:0]     rad;
		logic [ffe_pkg::ColorW-1:0]      col;
	} command_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	logic [ffe_pkg::OpW-1:0] opcode;
	logic signed [ffe_pkg::PosW-1:0] start_x, start_y, end_x, end_y;
	logic signed [ffe_pkg::RadiusW-1:0] radius;
	logic [ffe_pkg::ColorW-1:0] color;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [ffe_pkg::ColorW-1:0] read_color;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// predicted frame contents and registers
	logic [ffe_pkg::ColorW-1:0] frame_pixels [0:FRAME_MAX*FRAME_MAX-1];
	int cfg_w = 64;
	int cfg_h = 64;
	logic [ffe_pkg::ColorW-1:0] read_colors_due [$];

	int last_work = 0;
	int no_idle = 0;
	logic hold_rsp;
	int rsp_wait = 0;
	int mismatches = 0;
	int reads_checked = 0;
	int commands_sent = 0;
	int settings_used = 0;
	int cycle_count = 0;

	framebuffer_fill_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.opcode(opcode), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .radius(radius), .color(color),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .read_color(read_color),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reads still due", cycle_count,
				read_colors_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int idle_cycles();
		if (no_idle != 0)
			return 0;
		return int'($urandom_range(0, 12));
	endfunction

	// frame geometry, clamped like the block
	function automatic int active_w();
		return cfg_w > FRAME_MAX ? FRAME_MAX : cfg_w;
	endfunction

	function automatic int active_h();
		return cfg_h > FRAME_MAX ? FRAME_MAX : cfg_h;
	endfunction

	function automatic bit in_frame(int x, int y);
		return x >= 0 && y >= 0 && x < active_w() && y < active_h();
	endfunction

	function automatic void put_px(int x, int y, logic [ffe_pkg::ColorW-1:0] c);
		if (in_frame(x, y))
			frame_pixels[y * active_w() + x] = c;
	endfunction

	function automatic logic [ffe_pkg::ColorW-1:0] get_px(int x, int y);
		if (!in_frame(x, y))
			return '0;
		return frame_pixels[y * active_w() + x];
	endfunction

	function automatic int root_floor(int n);
		int r;
		r = 0;
		while ((r + 1) * (r + 1) <= n)
			r++;
		return r;
	endfunction

	// paint one command into the predicted frame; reads queue the color due back
	// last_work keeps a rough cycle count of the command for the pause before resizes
	function automatic void apply_to_frame(command_word_t w);
		int sx, sy, ex, ey, r, x, y, dx, dy, h;
		sx = int'($signed(w.sx));
		sy = int'($signed(w.sy));
		ex = int'($signed(w.ex));
		ey = int'($signed(w.ey));
		r = int'($signed(w.rad));
		case (w.op)
			ffe_pkg::OP_PLOT: begin
				put_px(sx, sy, w.col);
				last_work = 2;
			end
			ffe_pkg::OP_RECT: begin
				if (sx < 0) sx = 0;
				if (sy < 0) sy = 0;
				if (ex > active_w() - 1) ex = active_w() - 1;
				if (ey > active_h() - 1) ey = active_h() - 1;
				last_work = 1;
				for (y = sy; y <= ey; y++)
					for (x = sx; x <= ex; x++) begin
						put_px(x, y, w.col);
						last_work++;
					end
			end
			ffe_pkg::OP_DISC: begin
				last_work = 2;
				if (r <= 0)
					put_px(sx, sy, w.col);
				else
					for (dx = -r; dx < r; dx++) begin
						h = root_floor(r * r - dx * dx);
						last_work += 12 + 2 * h;
						for (dy = -h; dy < h; dy++)
							put_px(sx + dx, sy + dy, w.col);
					end
			end
			default: begin
				read_colors_due.push_back(get_px(sx, sy));
				last_work = 5;
			end
		endcase
	endfunction

	function automatic command_word_t word_of(ffe_pkg::opcode_t op, int sx, int sy,
			int ex, int ey, int r, logic [ffe_pkg::ColorW-1:0] c);
		command_word_t w;
		w.op = op;
		w.sx = sx[ffe_pkg::PosW-1:0];
		w.sy = sy[ffe_pkg::PosW-1:0];
		w.ex = ex[ffe_pkg::PosW-1:0];
		w.ey = ey[ffe_pkg::PosW-1:0];
		w.rad = r[ffe_pkg::RadiusW-1:0];
		w.col = c;
		return w;
	endfunction

	// mostly near the active frame, sometimes anywhere in the field range
	function automatic int random_coord(int span);
		if ($urandom_range(0, 99) < 15)
			return int'($urandom_range(0, 1023)) - 512;
		return int'($urandom_range(0, span + 7)) - 4;
	endfunction

	function automatic command_word_t random_command();
		command_word_t w;
		int pick;
		pick = int'($urandom_range(0, 99));
		w.op = pick < 20 ? ffe_pkg::OP_PLOT : pick < 40 ? ffe_pkg::OP_RECT :
			pick < 60 ? ffe_pkg::OP_DISC : ffe_pkg::OP_READ;
		w.sx = ffe_pkg::PosW'(random_coord(active_w()));
		w.sy = ffe_pkg::PosW'(random_coord(active_h()));
		// small boxes mostly; now and then a corner anywhere
		if ($urandom_range(0, 9) == 0)
			w.ex = ffe_pkg::PosW'($urandom_range(0, 1023));
		else
			w.ex = ffe_pkg::PosW'(int'(w.sx) + int'($urandom_range(0, 12)) - 2);
		if ($urandom_range(0, 9) == 0)
			w.ey = ffe_pkg::PosW'($urandom_range(0, 1023));
		else
			w.ey = ffe_pkg::PosW'(int'(w.sy) + int'($urandom_range(0, 12)) - 2);
		// small radii mostly, full range rarely
		if ($urandom_range(0, 99) < 8)
			w.rad = ffe_pkg::RadiusW'($urandom_range(0, 127));
		else
			w.rad = ffe_pkg::RadiusW'(int'($urandom_range(0, 7)) - 1);
		w.col = ffe_pkg::ColorW'($urandom_range(0, 24'hFFFFFF));
		return w;
	endfunction

	// send one command word and wait for the block to take it
	task automatic send_command(input command_word_t w);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= w.op;
		start_x <= w.sx;
		start_y <= w.sy;
		end_x <= w.ex;
		end_y <= w.ey;
		radius <= w.rad;
		color <= w.col;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		apply_to_frame(w);
		commands_sent++;
	endtask

	// all reads back, then time for the last fill to finish
	task automatic wait_for_idle();
		cmd_valid <= 1'b0;
		while (read_colors_due.size() != 0)
			@(posedge clk);
		repeat (2 * last_work + 64) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_register(input logic [2:0] addr,
			input logic [ffe_pkg::DimW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {{(32-ffe_pkg::DimW){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (addr)
			FRAME_WIDTH_ADDR:  cfg_w = int'(value);
			FRAME_HEIGHT_ADDR: cfg_h = int'(value);
			default: ;
		endcase
	endtask

	task automatic random_traffic(input int count);
		repeat (count) send_command(random_command());
	endtask

	task automatic hold_responses(input int cycles);
		hold_rsp <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_rsp <= 1'b0;
	endtask

	// cleared frame: blue inside, zero outside
	task automatic test_reset_contents();
		send_command(word_of(ffe_pkg::OP_READ, 0, 0, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, 63, 63, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, -1, 0, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, 64, 5, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, -512, 511, 0, 0, 0, 24'h0));
	endtask

	// single pixels at two corners and far outside
	task automatic test_plot_pixel();
		send_command(word_of(ffe_pkg::OP_PLOT, 0, 0, 0, 0, 0, 24'hFFFFFF));
		send_command(word_of(ffe_pkg::OP_PLOT, 63, 63, 0, 0, 0, 24'h000000));
		send_command(word_of(ffe_pkg::OP_PLOT, -512, -512, 511, 511, -64, 24'hABCDEF));
		send_command(word_of(ffe_pkg::OP_PLOT, 511, 511, -512, -512, 63, 24'h5A5A5A));
		send_command(word_of(ffe_pkg::OP_READ, 0, 0, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, 63, 63, 0, 0, 0, 24'h0));
	endtask

	// full clipped frame, reversed boxes on each axis, a small box
	task automatic test_rect_fill();
		send_command(word_of(ffe_pkg::OP_RECT, -512, -512, 511, 511, 0, 24'h123456));
		send_command(word_of(ffe_pkg::OP_RECT, 10, 10, 5, 20, 0, 24'hFF0000));
		send_command(word_of(ffe_pkg::OP_RECT, 10, 20, 15, 12, 0, 24'h00FF00));
		send_command(word_of(ffe_pkg::OP_RECT, 2, 3, 6, 4, 0, 24'hC0FFEE));
		send_command(word_of(ffe_pkg::OP_READ, 4, 3, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, 7, 3, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, 12, 15, 0, 0, 0, 24'h0));
	endtask

	// centre only for zero and negative radius, then the largest disc and an edge clip
	task automatic test_disc_fill();
		send_command(word_of(ffe_pkg::OP_DISC, 20, 20, 0, 0, 0, 24'h111111));
		send_command(word_of(ffe_pkg::OP_DISC, 30, 30, 0, 0, -1, 24'h222222));
		send_command(word_of(ffe_pkg::OP_DISC, 40, 40, 0, 0, -64, 24'h333333));
		send_command(word_of(ffe_pkg::OP_DISC, 32, 32, 0, 0, 63, 24'h444444));
		send_command(word_of(ffe_pkg::OP_DISC, 0, 0, 0, 0, 5, 24'h555555));
		send_command(word_of(ffe_pkg::OP_READ, 20, 20, 0, 0, 0, 24'h0));
		send_command(word_of(ffe_pkg::OP_READ, 4, 2, 0, 0, 0, 24'h0));
	endtask

	// resize between phases: empty, oversized, single pixel, odd stride, full
	task automatic test_frame_config();
		int widths [6];
		int heights [6];
		int i;
		widths = '{0, 64, 127, 1, 37, 64};
		heights = '{64, 0, 127, 1, 13, 64};
		for (i = 0; i < 6; i++) begin
			wait_for_idle();
			write_register(FRAME_WIDTH_ADDR, widths[i][ffe_pkg::DimW-1:0]);
			write_register(FRAME_HEIGHT_ADDR, heights[i][ffe_pkg::DimW-1:0]);
			settings_used++;
			no_idle = (i == 4) ? 1 : 0;
			random_traffic(14);
		end
		no_idle = 0;
	endtask

	// receiver holds off while reads keep coming, so the input stalls
	task automatic test_backpressure();
		int k;
		wait_for_idle();
		fork
			hold_responses(400);
		join_none
		no_idle = 1;
		for (k = 0; k < 10; k++)
			if (k % 2 == 0)
				send_command(word_of(ffe_pkg::OP_READ, int'($urandom_range(0, 63)),
					int'($urandom_range(0, 63)), 0, 0, 0, 24'h0));
			else
				send_command(word_of(ffe_pkg::OP_PLOT, int'($urandom_range(0, 63)),
					int'($urandom_range(0, 63)), 0, 0, 0,
					ffe_pkg::ColorW'($urandom_range(0, 24'hFFFFFF))));
		no_idle = 0;
	endtask

	// response stall: per word wait, counted only while a word is offered
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			rsp_wait = idle_cycles();
		else if (rsp_valid && rsp_wait > 0)
			rsp_wait--;
		rsp_stall <= hold_rsp || (rsp_wait > 0);
	end

	task automatic report_mismatch(input string what,
			input logic [ffe_pkg::ColorW-1:0] exp_col,
			input logic [ffe_pkg::ColorW-1:0] act_col);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s read_color expected %06h actual %06h", $realtime, what,
				exp_col, act_col);
	endtask

	// compare each read word with the oldest color due
	always @(posedge clk) begin
		logic [ffe_pkg::ColorW-1:0] due;
		if (arst_n && rsp_valid && !rsp_stall) begin
			reads_checked++;
			if (read_colors_due.size() == 0)
				report_mismatch("unexpected word,", 'x, read_color);
			else begin
				due = read_colors_due.pop_front();
				if (read_color !== due)
					report_mismatch("wrong color,", due, read_color);
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < FRAME_MAX * FRAME_MAX; i++)
			frame_pixels[i] = ffe_pkg::ClearColor;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		opcode <= '0;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		radius <= '0;
		color <= '0;
		hold_rsp <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		test_reset_contents();
		test_plot_pixel();
		test_rect_fill();
		test_disc_fill();
		random_traffic(21);
		test_frame_config();
		test_backpressure();
		wait_for_idle();

		$display("%0d command words sent over %0d frame settings, %0d read words checked",
			commands_sent, settings_used, reads_checked);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/ffe_pkg.sv
src/ffe_isqrt.sv
src/ffe_pixpipe.sv
src/ffe_dpath.sv
src/ffe_ctrl.sv
src/framebuffer_fill_engine_unit.sv
src/ffe_chk.sv
sim/testbench.sv
